/* sv/wsc_pkg.sv */
package wsc_pkg;

  // Default number of signature cells.
  localparam int unsigned PATTERN_MAX_DEF = 64;

  // Fixed field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned LEN_REG_W = 7;
  localparam int unsigned ADDR_W    = 32;

  // Stream and register port widths.
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Positions inside the slave-side tdata.
  localparam int unsigned CARE_POS = BYTE_W;
  localparam int unsigned IDX_LSB  = BYTE_W + 1;

  // Beat kinds carried on the slave-side tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_REGION_START   = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  // One signature entry: care bit above the byte.
  typedef struct packed {
    logic              care;
    logic [BYTE_W-1:0] value;
  } pat_entry_t;

endpackage

/* sv/wsc_ram.sv */
module wsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/wsc_cell.sv */
module wsc_cell (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [wsc_pkg::BYTE_W-1:0] byte_i,
  input  logic                       pat_we_i,
  input  wsc_pkg::pat_entry_t        pat_i,
  output logic [wsc_pkg::BYTE_W-1:0] byte_o,
  output logic                       hit_o
);
  import wsc_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  pat_entry_t        pat_q;
  logic              hit_q;

  // The compare is taken on the byte entering the cell, so the hit flag
  // always describes the window as it stands after the shift.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
      hit_q  <= !pat_q.care || (byte_i == pat_q.value);
    end
    if (pat_we_i) begin
      pat_q <= pat_i;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = hit_q;

endmodule

/* sv/wildcard_byte_signature_scan.sv */
// A scan beat is registered in the cell row and first stage, its result beat in the output register.
// The slave side takes one beat per cycle, loads and region bytes alike, while no sweep runs and
// the master side does not hold it back. A pattern_length write starts a realignment sweep through
// the signature memory, during which s_axis_tready is low. Reset is asynchronous, active low:
// it clears the control state, region_start to zero and pattern_length to one; pattern bytes
// stay undefined until loaded.
module wildcard_byte_signature_scan #(
  parameter int unsigned PatternMax = wsc_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] byte_value, [8] care, [14:9] pattern_index, [15] zero fill
  input  logic [wsc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  // Master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] match_address
  output logic [wsc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] found
  output logic [0:0]                    m_axis_tuser,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsc_pkg::PADDR_W-1:0]   paddr,
  input  logic [wsc_pkg::PDATA_W-1:0]   pwdata,
  output logic [wsc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import wsc_pkg::*;

  localparam int unsigned IdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;
  localparam int unsigned LenW = $clog2(PatternMax + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. The effective length (clamped into 1..PatternMax)
  // and its value minus one are kept alongside the raw value that reads back.
  // ---------------------------------------------------------------------------
  logic                 cfg_we;
  logic [ADDR_W-1:0]    region_start_q;
  logic [LEN_REG_W-1:0] len_raw_q, len_raw_w;
  logic [LenW-1:0]      len_q, len_new;
  logic [IdxW-1:0]      lm1_q;
  logic                 len_write;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign len_raw_w = pwdata[LEN_REG_W-1:0];
  assign len_write = cfg_we && (paddr[2] == REG_PATTERN_LENGTH);

  always_comb begin
    if (len_raw_w == '0) begin
      len_new = LenW'(1);
    end else if (32'(len_raw_w) > 32'(PatternMax)) begin
      len_new = LenW'(PatternMax);
    end else begin
      len_new = LenW'(len_raw_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      len_raw_q      <= LEN_REG_W'(1);
      len_q          <= LenW'(1);
      lm1_q          <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_REGION_START: begin
          region_start_q <= pwdata[ADDR_W-1:0];
        end
        REG_PATTERN_LENGTH: begin
          len_raw_q <= len_raw_w;
          len_q     <= len_new;
          lm1_q     <= IdxW'(len_new - LenW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REGION_START:   prdata = region_start_q;
      REG_PATTERN_LENGTH: prdata = PDATA_W'(len_raw_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Signature storage. The memory keeps every loaded entry by its index. Cell j
  // holds signature entry (length - 1 - j), so that it lines up with the window
  // byte of age j. A new length therefore needs the cells refilled: the sweep
  // reads the memory one entry a cycle and writes each into its new cell.
  // ---------------------------------------------------------------------------
  logic            sweep_busy_q, rd_pend_q;
  logic [LenW-1:0] sweep_cnt_q;
  logic [IdxW-1:0] rd_idx_q;
  pat_entry_t      ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_busy_q <= 1'b0;
      sweep_cnt_q  <= '0;
      rd_pend_q    <= 1'b0;
      rd_idx_q     <= '0;
    end else if (len_write) begin
      sweep_busy_q <= 1'b1;
      sweep_cnt_q  <= '0;
      rd_pend_q    <= 1'b0;
    end else if (sweep_busy_q) begin
      rd_pend_q   <= 1'b1;
      rd_idx_q    <= IdxW'(sweep_cnt_q);
      sweep_cnt_q <= sweep_cnt_q + LenW'(1);
      if (sweep_cnt_q == len_q - LenW'(1)) begin
        sweep_busy_q <= 1'b0;
      end
    end else begin
      rd_pend_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Slave-side handshake and beat decode.
  // ---------------------------------------------------------------------------
  logic             accept, is_scan, s2_valid_q, out_valid_q, out_free;
  logic [IDX_W-1:0] ld_idx;
  logic             ld_ok, ld_cell;
  pat_entry_t       ld_entry;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !sweep_busy_q && !rd_pend_q && (!s2_valid_q || out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_scan       = (s_axis_tuser[0] == KIND_SCAN);

  assign ld_idx         = s_axis_tdata[IDX_LSB +: IDX_W];
  assign ld_entry.care  = s_axis_tdata[CARE_POS];
  assign ld_entry.value = s_axis_tdata[BYTE_W-1:0];
  assign ld_ok          = accept && !is_scan && (32'(ld_idx) < 32'(PatternMax));
  assign ld_cell        = ld_ok && (32'(ld_idx) < 32'(len_q));

  wsc_ram #(
    .Width ($bits(pat_entry_t)),
    .Depth (PatternMax)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (ld_ok),
    .waddr_i (IdxW'(ld_idx)),
    .wdata_i (ld_entry),
    .raddr_i (IdxW'(sweep_cnt_q)),
    .rdata_o (ram_rdata)
  );

  // One cell write port, shared by loads and the sweep (never both at once).
  logic            cell_we;
  logic [IdxW-1:0] cell_slot;
  pat_entry_t      cell_wdata;

  always_comb begin
    if (rd_pend_q) begin
      cell_we    = 1'b1;
      cell_slot  = lm1_q - rd_idx_q;
      cell_wdata = ram_rdata;
    end else begin
      cell_we    = ld_cell;
      cell_slot  = lm1_q - IdxW'(ld_idx);
      cell_wdata = ld_entry;
    end
  end

  // ---------------------------------------------------------------------------
  // Region position tracking, first stage. Fill count saturates at PatternMax;
  // a window is only judged once it holds as many region bytes as the length.
  // ---------------------------------------------------------------------------
  logic              shift;
  logic [LenW-1:0]   fill_q, fill_new;
  logic [ADDR_W-1:0] offset_q;
  logic              s2_fill_ok_q, s2_last_q;
  logic [ADDR_W-1:0] s2_start_q;

  assign shift    = accept && is_scan;
  assign fill_new = (fill_q == LenW'(PatternMax)) ? fill_q : fill_q + LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      offset_q <= '0;
    end else if (shift) begin
      if (s_axis_tlast) begin
        fill_q   <= '0;
        offset_q <= '0;
      end else begin
        fill_q   <= fill_new;
        offset_q <= offset_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      s2_fill_ok_q <= (fill_new >= len_q);
      s2_last_q    <= s_axis_tlast;
      s2_start_q   <= offset_q + ADDR_W'(1) - ADDR_W'(len_q);
    end
  end

  // ---------------------------------------------------------------------------
  // The cell row: the window shifts one cell along per region byte, and each
  // cell registers its own compare.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]     win_byte [PatternMax];
  logic [PatternMax-1:0] hit, in_use;

  for (genvar j = 0; j < PatternMax; j++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    if (j == 0) begin : g_head
      assign byte_in = s_axis_tdata[BYTE_W-1:0];
    end else begin : g_link
      assign byte_in = win_byte[j-1];
    end
    assign in_use[j] = (32'(j) < 32'(len_q));

    wsc_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .byte_i   (byte_in),
      .pat_we_i (cell_we && (cell_slot == IdxW'(j))),
      .pat_i    (cell_wdata),
      .byte_o   (win_byte[j]),
      .hit_o    (hit[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Second stage: combine the cell hits and decide the result beat. Only the
  // first match of a region reports; the final byte reports not found when no
  // match came before it or on it, and ends the region.
  // ---------------------------------------------------------------------------
  logic              seen_q, all_hit, match_now, give_result, s2_go;
  logic              out_found_q;
  logic [ADDR_W-1:0] out_addr_q;

  assign all_hit     = &(hit | ~in_use);
  assign match_now   = s2_valid_q && !seen_q && s2_fill_ok_q && all_hit;
  assign give_result = match_now || (s2_valid_q && s2_last_q && !seen_q);
  assign s2_go       = s2_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (shift) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end

      if (s2_go) begin
        seen_q <= s2_last_q ? 1'b0 : (seen_q || match_now);
      end

      if (s2_go && give_result) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && give_result) begin
      out_found_q <= match_now;
      out_addr_q  <= match_now ? (region_start_q + s2_start_q) : '0;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_addr_q;
  assign m_axis_tuser[0] = out_found_q;

`ifndef NO_ASSERTIONS
  // No beat may enter while the cells are being realigned.
  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sweep_busy_q || rd_pend_q) |-> !s_axis_tready)
    else $error("input accepted during signature realignment");

  // A not-found beat always carries a zero address.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("not-found beat with non-zero address");

  // The fill count never passes the number of cells.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(PatternMax))
    else $error("fill count beyond cell count");

  // The end of a region leaves no match recorded for the next one.
  a_region_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && s2_last_q) |=> !seen_q)
    else $error("match flag survived the end of a region");

  // A region byte consumed at the second stage that matches must give a beat.
  a_match_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_go && match_now) |=> (m_axis_tvalid && m_axis_tuser[0]))
    else $error("match found but no result beat");
`endif

endmodule
